### rtl/bsn_pkg.sv
// ----------------------------------------------------------------------------
// Box sort and suppression package
// Shared constants, payload types and fixed-point helpers for the unit.
// ----------------------------------------------------------------------------
package bsn_pkg;

   // Default sizes of the unit.
   localparam int BOX_CAPACITY_DEF = 64;
   localparam int KEEP_MAX_DEF     = 8;

   // Fraction bits of the normalized inputs.
   localparam int CENTRE_FRAC = 20;
   localparam int SIZE_FRAC   = 26;

   // Depth of the queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 4;

   // Register widths and reset values.
   localparam int THR_W      = 20;
   localparam int SCALE_W    = 12;
   localparam int KEEP_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int PROD_W     = 45;

   localparam logic [THR_W-1:0]   THR_RESET     = 20'd250;
   localparam logic [SCALE_W-1:0] SCALE_X_RESET = 12'd160;
   localparam logic [SCALE_W-1:0] SCALE_Y_RESET = 12'd128;
   localparam logic [KEEP_W-1:0]  KEEP_RESET    = 4'd1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OVERLAP_THRESHOLD = 2'd0,
      CSR_SCALE_X           = 2'd1,
      CSR_SCALE_Y           = 2'd2,
      CSR_KEEP_COUNT        = 2'd3
   } csr_index_type;

   // Request payload.
   typedef struct packed {
      logic signed [15:0] box_score;
      logic signed [31:0] center_x_raw;
      logic signed [31:0] center_y_raw;
      logic signed [31:0] width_raw;
      logic signed [31:0] height_raw;
      logic [7:0]         class_id;
      logic               is_alive;
      logic               last_box;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic signed [15:0] out_score;
      logic signed [15:0] left_x;
      logic signed [15:0] top_y;
      logic signed [15:0] pixel_width;
      logic signed [15:0] pixel_height;
      logic [7:0]         out_class;
      logic               no_boxes;
      logic               last_result;
   } rsp_type;

   // Box geometry in pixels.
   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] width;
      logic signed [15:0] height;
   } geom_type;

   // One stored candidate.
   typedef struct packed {
      logic               alive;
      logic signed [15:0] score;
      logic [7:0]         class_id;
      geom_type           geom;
   } box_entry_type;

   // One queue entry from front to back.
   typedef struct packed {
      logic          last_box;
      box_entry_type box;
   } queue_entry_type;

   // Saturate a product-wide value to signed 16 bits.
   function automatic logic signed [15:0] sat_wide(input logic signed [PROD_W-1:0] v);
      logic signed [15:0] r;
      if (v > 45'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -45'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Saturate a 17-bit difference to signed 16 bits.
   function automatic logic signed [15:0] sat_diff(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v > 17'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -17'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Divide a product by 2^frac, truncating toward zero, then saturate.
   function automatic logic signed [15:0] scale_down(input logic signed [PROD_W-1:0] p,
                                                     input int unsigned frac);
      logic signed [PROD_W-1:0] bias;
      logic signed [PROD_W-1:0] q;
      bias = p[PROD_W-1] ? ((45'sd1 <<< frac) - 45'sd1) : '0;
      q    = (p + bias) >>> frac;
      return sat_wide(q);
   endfunction

   // Left or top edge: centre minus half the size, half truncated toward zero.
   function automatic logic signed [15:0] edge_of(input logic signed [15:0] c,
                                                  input logic signed [15:0] s);
      logic signed [16:0] half;
      half = $signed(17'(s) + 17'(s[15])) >>> 1;
      return sat_diff(17'(c) - half);
   endfunction

   // Build a result from a stored box.
   function automatic rsp_type make_rsp(input box_entry_type b, input logic last);
      rsp_type r;
      r.out_score    = b.score;
      r.left_x       = b.geom.left;
      r.top_y        = b.geom.top;
      r.pixel_width  = b.geom.width;
      r.pixel_height = b.geom.height;
      r.out_class    = b.class_id;
      r.no_boxes     = 1'b0;
      r.last_result  = last;
      return r;
   endfunction

endpackage

### rtl/box_sort_nms_unit.sv
// ----------------------------------------------------------------------------
// Box sort and non-maximum suppression unit
// Loads candidate boxes, orders them by score and emits the kept boxes.
// ----------------------------------------------------------------------------
// Boxes load at one request per cycle while the queue has room: a two-stage
// conversion pipeline turns each alive box into pixel geometry and a
// four-entry queue feeds the store. The request with last_box set closes the
// set. The walk then runs selection passes over the store, one stored box per
// cycle through a single RAM read port; each pick is checked against every
// box already kept, one after another through CK_READ, CK_DIFF, CK_MUL and
// CK_CMP, and a pass that finds no further candidate, or a pick that reaches
// the keep limit, ends the set. Requests for the next set wait in the queue
// meanwhile.
// Results come out of a register, one per cycle at most, the last one flagged.
// ----------------------------------------------------------------------------
module box_sort_nms_unit #(
   parameter int BOX_CAPACITY = bsn_pkg::BOX_CAPACITY_DEF,
   parameter int KEEP_MAX     = bsn_pkg::KEEP_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bsn_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bsn_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_en,
   input  logic [bsn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsn_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [bsn_pkg::THR_W-1:0]   thr_ff, thr_in;
   logic [bsn_pkg::SCALE_W-1:0] scale_x_ff, scale_x_in;
   logic [bsn_pkg::SCALE_W-1:0] scale_y_ff, scale_y_in;
   logic [bsn_pkg::KEEP_W-1:0]  keep_ff, keep_in;

   logic                        push_valid, push_ready, pop_valid, pop_ready;
   bsn_pkg::queue_entry_type    push_data, pop_data;

   // Configuration register writes.
   always_comb begin
      thr_in     = thr_ff;
      scale_x_in = scale_x_ff;
      scale_y_in = scale_y_ff;
      keep_in    = keep_ff;
      if (csr_write_en) begin
         unique case (bsn_pkg::csr_index_type'(csr_index))
            bsn_pkg::CSR_OVERLAP_THRESHOLD: thr_in = csr_wdata[bsn_pkg::THR_W-1:0];
            bsn_pkg::CSR_SCALE_X:           scale_x_in = csr_wdata[bsn_pkg::SCALE_W-1:0];
            bsn_pkg::CSR_SCALE_Y:           scale_y_in = csr_wdata[bsn_pkg::SCALE_W-1:0];
            bsn_pkg::CSR_KEEP_COUNT:        keep_in = csr_wdata[bsn_pkg::KEEP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= bsn_pkg::THR_RESET;
         scale_x_ff <= bsn_pkg::SCALE_X_RESET;
         scale_y_ff <= bsn_pkg::SCALE_Y_RESET;
         keep_ff    <= bsn_pkg::KEEP_RESET;
      end else begin
         thr_ff     <= thr_in;
         scale_x_ff <= scale_x_in;
         scale_y_ff <= scale_y_in;
         keep_ff    <= keep_in;
      end
   end

   // Conversion front end.
   bsn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .scale_x    (scale_x_ff),
      .scale_y    (scale_y_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Queue between front and back.
   bsn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Sort and suppression engine.
   bsn_back #(.BOX_CAPACITY(BOX_CAPACITY), .KEEP_MAX(KEEP_MAX)) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .overlap_threshold (thr_ff),
      .keep_count        (keep_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data)
   );

endmodule

### rtl/bsn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read into a registered read data output.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bsn_front.sv
// ----------------------------------------------------------------------------
// Box conversion front end
// Accepts requests and converts alive boxes to pixel geometry.
// ----------------------------------------------------------------------------
module bsn_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bsn_pkg::req_type                req_data,
   input  logic [bsn_pkg::SCALE_W-1:0]     scale_x,
   input  logic [bsn_pkg::SCALE_W-1:0]     scale_y,
   output logic                            push_valid,
   input  logic                            push_ready,
   output bsn_pkg::queue_entry_type        push_data
);

   logic signed [bsn_pkg::PROD_W-1:0] cx_prod_ff, cx_prod_in;
   logic signed [bsn_pkg::PROD_W-1:0] cy_prod_ff, cy_prod_in;
   logic signed [bsn_pkg::PROD_W-1:0] w_prod_ff, w_prod_in;
   logic signed [bsn_pkg::PROD_W-1:0] h_prod_ff, h_prod_in;
   bsn_pkg::req_type                  meta_ff, meta_in;
   logic                              s1_valid_ff, s1_valid_in;
   logic signed [12:0]                sx_ext, sy_ext;
   logic signed [15:0]                cx, cy, w, h;
   logic                              take;

   assign req_ready = !s1_valid_ff || push_ready;
   assign take      = req_valid && req_ready;
   assign sx_ext    = $signed({1'b0, scale_x});
   assign sy_ext    = $signed({1'b0, scale_y});

   // First stage: the four products.
   always_comb begin
      s1_valid_in = take || (s1_valid_ff && !push_ready);
      cx_prod_in  = cx_prod_ff;
      cy_prod_in  = cy_prod_ff;
      w_prod_in   = w_prod_ff;
      h_prod_in   = h_prod_ff;
      meta_in     = meta_ff;
      if (take) begin
         cx_prod_in = req_data.center_x_raw * sx_ext;
         cy_prod_in = req_data.center_y_raw * sy_ext;
         w_prod_in  = req_data.width_raw * sx_ext;
         h_prod_in  = req_data.height_raw * sy_ext;
         meta_in    = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      cx_prod_ff <= cx_prod_in;
      cy_prod_ff <= cy_prod_in;
      w_prod_ff  <= w_prod_in;
      h_prod_ff  <= h_prod_in;
      meta_ff    <= meta_in;
   end

   // Second stage: scale down, saturate and find the edges.
   always_comb begin
      cx = bsn_pkg::scale_down(cx_prod_ff, bsn_pkg::CENTRE_FRAC);
      cy = bsn_pkg::scale_down(cy_prod_ff, bsn_pkg::CENTRE_FRAC);
      w  = bsn_pkg::scale_down(w_prod_ff, bsn_pkg::SIZE_FRAC);
      h  = bsn_pkg::scale_down(h_prod_ff, bsn_pkg::SIZE_FRAC);
      push_data.last_box     = meta_ff.last_box;
      push_data.box.alive    = meta_ff.is_alive;
      push_data.box.score    = meta_ff.box_score;
      push_data.box.class_id = meta_ff.class_id;
      push_data.box.geom     = '0;
      if (meta_ff.is_alive) begin
         push_data.box.geom.left   = bsn_pkg::edge_of(cx, w);
         push_data.box.geom.top    = bsn_pkg::edge_of(cy, h);
         push_data.box.geom.width  = w;
         push_data.box.geom.height = h;
      end
   end

   assign push_valid = s1_valid_ff;

endmodule

### rtl/bsn_queue.sv
// ----------------------------------------------------------------------------
// Front to back queue
// A short register queue that lets front and back stall on their own.
// ----------------------------------------------------------------------------
module bsn_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  bsn_pkg::queue_entry_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output bsn_pkg::queue_entry_type pop_data
);

   localparam int QAW = $clog2(bsn_pkg::QUEUE_DEPTH);
   localparam int QCW = $clog2(bsn_pkg::QUEUE_DEPTH + 1);

   bsn_pkg::queue_entry_type entries_ff [bsn_pkg::QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != QCW'(bsn_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? QAW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bsn_back.sv
// ----------------------------------------------------------------------------
// Sort and suppression engine
// Stores a set of boxes, walks them in score order and emits the survivors.
// ----------------------------------------------------------------------------
module bsn_back #(
   parameter int BOX_CAPACITY = bsn_pkg::BOX_CAPACITY_DEF,
   parameter int KEEP_MAX     = bsn_pkg::KEEP_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  bsn_pkg::queue_entry_type      pop_data,
   input  logic [bsn_pkg::THR_W-1:0]     overlap_threshold,
   input  logic [bsn_pkg::KEEP_W-1:0]    keep_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bsn_pkg::rsp_type              rsp_data
);

   localparam int CW      = $clog2(BOX_CAPACITY + 1);
   localparam int AW      = (BOX_CAPACITY > 1) ? $clog2(BOX_CAPACITY) : 1;
   localparam int KCW     = $clog2(KEEP_MAX + 1);
   localparam int KAW     = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
   localparam int ENTRY_W = $bits(bsn_pkg::box_entry_type);
   localparam int GEOM_W  = $bits(bsn_pkg::geom_type);

   typedef enum logic [2:0] {
      ST_LOAD, ST_SCAN, ST_CK_READ, ST_CK_DIFF, ST_CK_MUL, ST_CK_CMP, ST_KEEP, ST_FLUSH
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 scan_addr_ff, scan_addr_in;
   logic [CW-1:0]                 scan_didx_ff, scan_didx_in;
   logic                          scan_dv_ff, scan_dv_in;
   logic                          found_ff, found_in;
   bsn_pkg::box_entry_type        best_ff, best_in;
   logic [CW-1:0]                 best_idx_ff, best_idx_in;
   logic                          prev_valid_ff, prev_valid_in;
   logic signed [15:0]            prev_score_ff, prev_score_in;
   logic [CW-1:0]                 prev_idx_ff, prev_idx_in;
   logic [KCW-1:0]                kcnt_ff, kcnt_in;
   logic [KCW-1:0]                chk_idx_ff, chk_idx_in;
   logic signed [17:0]            ovl_x_ff, ovl_x_in;
   logic signed [17:0]            ovl_y_ff, ovl_y_in;
   logic                          ovl_pos_ff, ovl_pos_in;
   logic signed [35:0]            area_ff, area_in;
   logic                          pend_valid_ff, pend_valid_in;
   bsn_pkg::box_entry_type        pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bsn_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          box_wr_en;
   bsn_pkg::box_entry_type        box_rd;
   logic                          kept_wr_en;
   bsn_pkg::geom_type             kept_rd;
   logic [6:0]                    lim_wide;
   logic [KCW-1:0]                lim;
   logic [KCW-1:0]                kcnt_next;
   logic                          slot_free, eligible, take, suppress;
   logic signed [15:0]            x0, y0;
   logic signed [16:0]            ax2, bx2, ay2, by2, x1, y1;

   // Candidate store, one entry per loaded box.
   bsn_ram #(.WIDTH(ENTRY_W), .DEPTH(BOX_CAPACITY)) u_box_ram (
      .clock   (clock),
      .wr_en   (box_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (pop_data.box),
      .rd_addr (scan_addr_ff[AW-1:0]),
      .rd_data (box_rd)
   );

   // Geometry of the boxes kept so far.
   bsn_ram #(.WIDTH(GEOM_W), .DEPTH(KEEP_MAX)) u_kept_ram (
      .clock   (clock),
      .wr_en   (kept_wr_en),
      .wr_addr (kcnt_ff[KAW-1:0]),
      .wr_data (best_ff.geom),
      .rd_addr (chk_idx_ff[KAW-1:0]),
      .rd_data (kept_rd)
   );

   // Effective number of results to emit.
   always_comb begin
      if (keep_count == '0) begin
         lim_wide = 7'd1;
      end else if ({3'b000, keep_count} > 7'(KEEP_MAX)) begin
         lim_wide = 7'(KEEP_MAX);
      end else begin
         lim_wide = {3'b000, keep_count};
      end
      lim       = KCW'(lim_wide);
      kcnt_next = KCW'(kcnt_ff + 1'b1);
   end

   // Scan: the next box in stable descending score order after the last pick.
   always_comb begin
      eligible = scan_dv_ff && box_rd.alive &&
                 (!prev_valid_ff || (box_rd.score < prev_score_ff) ||
                  ((box_rd.score == prev_score_ff) && (scan_didx_ff > prev_idx_ff)));
      take     = eligible && (!found_ff || (box_rd.score > best_ff.score));
   end

   // Overlap extents of the candidate against one kept box.
   always_comb begin
      ax2 = 17'(best_ff.geom.left) + 17'(best_ff.geom.width);
      bx2 = 17'(kept_rd.left) + 17'(kept_rd.width);
      ay2 = 17'(best_ff.geom.top) + 17'(best_ff.geom.height);
      by2 = 17'(kept_rd.top) + 17'(kept_rd.height);
      x0  = (best_ff.geom.left > kept_rd.left) ? best_ff.geom.left : kept_rd.left;
      y0  = (best_ff.geom.top > kept_rd.top) ? best_ff.geom.top : kept_rd.top;
      x1  = (ax2 < bx2) ? ax2 : bx2;
      y1  = (ay2 < by2) ? ay2 : by2;
      suppress = ovl_pos_ff ? (area_ff >= $signed({16'd0, overlap_threshold}))
                            : (overlap_threshold == '0);
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next-state logic of the walk.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      scan_didx_in  = scan_didx_ff;
      scan_dv_in    = 1'b0;
      found_in      = found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      prev_valid_in = prev_valid_ff;
      prev_score_in = prev_score_ff;
      prev_idx_in   = prev_idx_ff;
      kcnt_in       = kcnt_ff;
      chk_idx_in    = chk_idx_ff;
      ovl_x_in      = ovl_x_ff;
      ovl_y_in      = ovl_y_ff;
      ovl_pos_in    = ovl_pos_ff;
      area_in       = area_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      box_wr_en     = 1'b0;
      kept_wr_en    = 1'b0;
      pop_ready     = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               // A full store drops the box, but its last flag still counts.
               if (count_ff < CW'(BOX_CAPACITY)) begin
                  box_wr_en = 1'b1;
                  count_in  = CW'(count_ff + 1'b1);
               end
               if (pop_data.last_box) begin
                  state_in      = ST_SCAN;
                  scan_addr_in  = '0;
                  found_in      = 1'b0;
                  prev_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff < count_ff) begin
               scan_addr_in = CW'(scan_addr_ff + 1'b1);
               scan_didx_in = scan_addr_ff;
               scan_dv_in   = 1'b1;
            end
            if (take) begin
               found_in    = 1'b1;
               best_in     = box_rd;
               best_idx_in = scan_didx_ff;
            end
            // End of a pass: check the pick, keep it when none are kept yet, or finish the set.
            if ((scan_addr_ff == count_ff) && !scan_dv_ff) begin
               if (found_ff) begin
                  prev_valid_in = 1'b1;
                  prev_score_in = best_ff.score;
                  prev_idx_in   = best_idx_ff;
                  chk_idx_in    = '0;
                  state_in      = (kcnt_ff == '0) ? ST_KEEP : ST_CK_READ;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_CK_READ: begin
            state_in = ST_CK_DIFF;
         end
         ST_CK_DIFF: begin
            ovl_x_in   = 18'(x1) - 18'(x0);
            ovl_y_in   = 18'(y1) - 18'(y0);
            ovl_pos_in = (18'(x1) - 18'(x0) > 18'sd0) && (18'(y1) - 18'(y0) > 18'sd0);
            state_in   = ST_CK_MUL;
         end
         ST_CK_MUL: begin
            area_in  = ovl_x_ff * ovl_y_ff;
            state_in = ST_CK_CMP;
         end
         ST_CK_CMP: begin
            if (suppress) begin
               state_in     = ST_SCAN;
               scan_addr_in = '0;
               found_in     = 1'b0;
            end else if (KCW'(chk_idx_ff + 1'b1) == kcnt_ff) begin
               state_in = ST_KEEP;
            end else begin
               chk_idx_in = KCW'(chk_idx_ff + 1'b1);
               state_in   = ST_CK_READ;
            end
         end
         ST_KEEP: begin
            // The earlier survivor leaves now; the new one waits as pending.
            if (!pend_valid_ff || slot_free) begin
               kept_wr_en = 1'b1;
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = bsn_pkg::make_rsp(pend_ff, 1'b0);
               end
               pend_in       = best_ff;
               pend_valid_in = 1'b1;
               kcnt_in       = kcnt_next;
               if (kcnt_next == lim) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in     = ST_SCAN;
                  scan_addr_in = '0;
                  found_in     = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in = bsn_pkg::make_rsp(pend_ff, 1'b1);
               end else begin
                  rsp_data_in             = '0;
                  rsp_data_in.no_boxes    = 1'b1;
                  rsp_data_in.last_result = 1'b1;
               end
               count_in      = '0;
               kcnt_in       = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         scan_addr_ff  <= '0;
         scan_dv_ff    <= 1'b0;
         found_ff      <= 1'b0;
         prev_valid_ff <= 1'b0;
         kcnt_ff       <= '0;
         chk_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_addr_ff  <= scan_addr_in;
         scan_dv_ff    <= scan_dv_in;
         found_ff      <= found_in;
         prev_valid_ff <= prev_valid_in;
         kcnt_ff       <= kcnt_in;
         chk_idx_ff    <= chk_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_didx_ff  <= scan_didx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      prev_score_ff <= prev_score_in;
      prev_idx_ff   <= prev_idx_in;
      ovl_x_ff      <= ovl_x_in;
      ovl_y_ff      <= ovl_y_in;
      ovl_pos_ff    <= ovl_pos_in;
      area_ff       <= area_in;
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/bsn_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the unit over time and flags broken results.
// ----------------------------------------------------------------------------
module bsn_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bsn_pkg::rsp_type rsp_data
);

   // A result that is not taken stays and keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // An empty result closes its set and carries no box.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_boxes |->
         rsp_data.last_result && rsp_data.out_score == '0 && rsp_data.out_class == '0 &&
         rsp_data.pixel_width == '0 && rsp_data.pixel_height == '0)
      else $error("malformed empty result");

   // Nothing is shown in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind box_sort_nms_unit bsn_checker u_bsn_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### test/box_sort_nms_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box sort and suppression unit testbench
// Streams sets of candidate boxes through the unit under random idling on
// both channels, predicts the kept boxes with an in-bench model of the
// sort and greedy area suppression, and checks every result in order.
// ----------------------------------------------------------------------------
module box_sort_nms_unit_tb;

   localparam int CAP  = bsn_pkg::BOX_CAPACITY_DEF;
   localparam int KMAX = bsn_pkg::KEEP_MAX_DEF;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   bsn_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   bsn_pkg::rsp_type              rsp_data;
   logic                          csr_write_en;
   logic [bsn_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bsn_pkg::CSR_DATA_W-1:0] csr_wdata;

   box_sort_nms_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow registers and the shadow box store.
   int unsigned thr_sh, scx_sh, scy_sh, keep_sh;
   shortint     sc_st [CAP];
   shortint     lx_st [CAP];
   shortint     ty_st [CAP];
   shortint     pw_st [CAP];
   shortint     ph_st [CAP];
   byte unsigned cl_st [CAP];
   bit          al_st [CAP];
   int          n_loaded;

   bsn_pkg::req_type pending_boxes [$];
   bsn_pkg::rsp_type kept_boxes [$];
   int          errors;
   bit          idle_on;
   bit          req_took;
   int          req_gap;
   int          rsp_stall;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Draws an idle length: mostly none or short, now and then long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic note_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Normalized value times scale, divided by 2^frac toward zero, saturated.
   function automatic shortint to_pixels(int raw, int unsigned scale, int frac);
      longint q;
      q = (longint'(raw) * longint'(scale)) / (longint'(1) <<< frac);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return shortint'(q);
   endfunction

   function automatic longint overlap(int a, int b);
      int x, y, sx, sy, ax2, bx2, ay2, by2;
      x = lx_st[a] > lx_st[b] ? lx_st[a] : lx_st[b];
      y = ty_st[a] > ty_st[b] ? ty_st[a] : ty_st[b];
      ax2 = lx_st[a] + pw_st[a];
      bx2 = lx_st[b] + pw_st[b];
      ay2 = ty_st[a] + ph_st[a];
      by2 = ty_st[b] + ph_st[b];
      sx = (ax2 < bx2 ? ax2 : bx2) - x;
      sy = (ay2 < by2 ? ay2 : by2) - y;
      if (sx <= 0 || sy <= 0) return 0;
      return longint'(sx) * longint'(sy);
   endfunction

   // Stores one accepted request; a closing request runs sort and suppression.
   task automatic load_and_suppress(bsn_pkg::req_type r);
      int order [CAP];
      bit live [CAP];
      int i, j, cur, lim, cnt, w, h;
      bsn_pkg::rsp_type res;
      shortint cx, cy;
      if (n_loaded < CAP) begin
         sc_st[n_loaded] = r.box_score;
         cl_st[n_loaded] = r.class_id;
         al_st[n_loaded] = r.is_alive;
         lx_st[n_loaded] = 16'sd0; ty_st[n_loaded] = 16'sd0;
         pw_st[n_loaded] = 16'sd0; ph_st[n_loaded] = 16'sd0;
         if (r.is_alive) begin
            cx = to_pixels(r.center_x_raw, scx_sh, bsn_pkg::CENTRE_FRAC);
            cy = to_pixels(r.center_y_raw, scy_sh, bsn_pkg::CENTRE_FRAC);
            w  = to_pixels(r.width_raw, scx_sh, bsn_pkg::SIZE_FRAC);
            h  = to_pixels(r.height_raw, scy_sh, bsn_pkg::SIZE_FRAC);
            i = cx - w / 2;
            j = cy - h / 2;
            lx_st[n_loaded] = shortint'(i > 32767 ? 32767 : (i < -32768 ? -32768 : i));
            ty_st[n_loaded] = shortint'(j > 32767 ? 32767 : (j < -32768 ? -32768 : j));
            pw_st[n_loaded] = shortint'(w);
            ph_st[n_loaded] = shortint'(h);
         end
         n_loaded++;
      end
      if (!r.last_box) return;
      // Stable ordering by descending score.
      for (i = 0; i < n_loaded; i++) begin
         cur = i;
         j = i;
         while (j > 0 && sc_st[order[j-1]] < sc_st[cur]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = cur;
      end
      for (i = 0; i < n_loaded; i++) live[i] = al_st[order[i]];
      for (i = 0; i < n_loaded; i++) begin
         if (!live[i]) continue;
         for (j = 0; j < n_loaded; j++) begin
            if (!live[j] || j == i) continue;
            if (overlap(order[i], order[j]) >= longint'(thr_sh)) live[j] = 1'b0;
         end
      end
      lim = keep_sh == 0 ? 1 : (keep_sh > KMAX ? KMAX : keep_sh);
      cnt = 0;
      for (i = 0; i < n_loaded && cnt < lim; i++) begin
         if (!live[i]) continue;
         cur = order[i];
         res.out_score    = sc_st[cur];
         res.left_x       = lx_st[cur];
         res.top_y        = ty_st[cur];
         res.pixel_width  = pw_st[cur];
         res.pixel_height = ph_st[cur];
         res.out_class    = cl_st[cur];
         res.no_boxes     = 1'b0;
         res.last_result  = 1'b0;
         kept_boxes.push_back(res);
         cnt++;
      end
      if (cnt == 0) begin
         res = '0;
         res.no_boxes = 1'b1;
         kept_boxes.push_back(res);
      end
      kept_boxes[kept_boxes.size()-1].last_result = 1'b1;
      n_loaded = 0;
   endtask

   // Request driver: presents queued boxes with random gaps between them.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_boxes.size() > 0) begin
            req_data  <= pending_boxes.pop_front();
            req_valid <= 1'b1;
            req_gap   <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall <= draw_gap();
      end
   end

   // Monitor: feeds the predictor and checks each result against the oldest one.
   always @(posedge clock) begin
      bsn_pkg::rsp_type want;
      req_took <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) load_and_suppress(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (kept_boxes.size() == 0) begin
            note_mismatch("unexpected result count", 1, 0);
         end else begin
            want = kept_boxes.pop_front();
            if (rsp_data.out_score != want.out_score)
               note_mismatch("out_score", rsp_data.out_score, want.out_score);
            if (rsp_data.left_x != want.left_x)
               note_mismatch("left_x", rsp_data.left_x, want.left_x);
            if (rsp_data.top_y != want.top_y)
               note_mismatch("top_y", rsp_data.top_y, want.top_y);
            if (rsp_data.pixel_width != want.pixel_width)
               note_mismatch("pixel_width", rsp_data.pixel_width, want.pixel_width);
            if (rsp_data.pixel_height != want.pixel_height)
               note_mismatch("pixel_height", rsp_data.pixel_height, want.pixel_height);
            if (rsp_data.out_class != want.out_class)
               note_mismatch("out_class", rsp_data.out_class, want.out_class);
            if (rsp_data.no_boxes != want.no_boxes)
               note_mismatch("no_boxes", rsp_data.no_boxes, want.no_boxes);
            if (rsp_data.last_result != want.last_result)
               note_mismatch("last_result", rsp_data.last_result, want.last_result);
         end
      end
   end

   task automatic write_reg(bsn_pkg::csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= bsn_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         bsn_pkg::CSR_OVERLAP_THRESHOLD: thr_sh  = value & 32'hFFFFF;
         bsn_pkg::CSR_SCALE_X:           scx_sh  = value & 32'hFFF;
         bsn_pkg::CSR_SCALE_Y:           scy_sh  = value & 32'hFFF;
         bsn_pkg::CSR_KEEP_COUNT:        keep_sh = value & 32'hF;
      endcase
   endtask

   // Waits until every queued request is taken and every result has arrived.
   task automatic drain();
      while (pending_boxes.size() > 0 || req_valid || kept_boxes.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Builds one random box; most are plausible, some carry raw noise.
   function automatic bsn_pkg::req_type random_box(bit last);
      bsn_pkg::req_type b;
      b.box_score = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3) * 1000)
                                              : 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         b.center_x_raw = $urandom;
         b.center_y_raw = $urandom;
         b.width_raw    = $urandom;
         b.height_raw   = $urandom;
      end else begin
         b.center_x_raw = $urandom_range(0, 1 << 20);
         b.center_y_raw = $urandom_range(0, 1 << 20);
         b.width_raw    = $urandom_range(0, 1 << 25);
         b.height_raw   = $urandom_range(0, 1 << 25);
      end
      b.class_id = 8'($urandom);
      b.is_alive = $urandom_range(0, 99) < 85;
      b.last_box = last;
      return b;
   endfunction

   task automatic queue_set(int n);
      for (int i = 0; i < n; i++) pending_boxes.push_back(random_box(i == n - 1));
   endtask

   initial begin
      bsn_pkg::req_type b;
      int sent, n, ph;
      int unsigned thr_list [6] = '{0, 1048575, 250, 1, 40, 600};
      int unsigned sx_list  [6] = '{0, 4095, 160, 640, 4095, 320};
      int unsigned sy_list  [6] = '{4095, 0, 128, 480, 1, 240};
      int unsigned kp_list  [6] = '{0, 15, 8, 1, 3, 8};
      errors = 0; n_loaded = 0; req_gap = 0; rsp_stall = 0; idle_on = 1'b1;
      thr_sh = bsn_pkg::THR_RESET; scx_sh = bsn_pkg::SCALE_X_RESET;
      scy_sh = bsn_pkg::SCALE_Y_RESET; keep_sh = bsn_pkg::KEEP_RESET;
      reset = 1'b1; req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      req_took = 1'b0;
      csr_write_en = 1'b0; csr_index = bsn_pkg::CSR_OVERLAP_THRESHOLD; csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed sets under reset settings: field extremes, dead boxes, no survivors.
      b = '0; b.is_alive = 1'b1;
      b.box_score = 16'sh7fff; b.center_x_raw = 32'h7fffffff; b.center_y_raw = 32'h80000000;
      b.width_raw = 32'h7fffffff; b.height_raw = 32'h80000000; b.class_id = 8'hff;
      pending_boxes.push_back(b);
      b.box_score = 16'sh8000; b.center_x_raw = 32'h80000000; b.center_y_raw = 32'h7fffffff;
      b.width_raw = 32'h80000000; b.height_raw = 32'h7fffffff; b.class_id = 8'h00;
      pending_boxes.push_back(b);
      b = '0; b.is_alive = 1'b0; b.box_score = 16'sh7fff; b.class_id = 8'h5a;
      pending_boxes.push_back(b);
      // Two identical boxes with equal scores: the first loaded one wins.
      b = '0; b.is_alive = 1'b1; b.box_score = 16'sd100; b.class_id = 8'd1;
      b.center_x_raw = 1 << 19; b.center_y_raw = 1 << 19;
      b.width_raw = 1 << 24; b.height_raw = 1 << 24;
      pending_boxes.push_back(b);
      b.class_id = 8'd2;
      pending_boxes.push_back(b);
      // Edge-touching box: zero overlap.
      b.class_id = 8'd3; b.center_x_raw = (1 << 19) + 262144;
      b.last_box = 1'b1;
      pending_boxes.push_back(b);
      // A set holding only a dead box gives the empty result.
      b = '0; b.last_box = 1'b1; b.box_score = 16'sh7fff;
      pending_boxes.push_back(b);
      // A lone alive zero-size box.
      b = '0; b.is_alive = 1'b1; b.last_box = 1'b1;
      pending_boxes.push_back(b);
      queue_set(4);
      queue_set(1);
      drain();

      // Random phases, each under new register settings.
      sent = 0;
      for (ph = 0; ph < 8; ph++) begin
         write_reg(bsn_pkg::CSR_OVERLAP_THRESHOLD,
                   ph < 6 ? thr_list[ph] : $urandom_range(0, 2000));
         write_reg(bsn_pkg::CSR_SCALE_X, ph < 6 ? sx_list[ph] : $urandom_range(0, 4095));
         write_reg(bsn_pkg::CSR_SCALE_Y, ph < 6 ? sy_list[ph] : $urandom_range(0, 4095));
         write_reg(bsn_pkg::CSR_KEEP_COUNT, ph < 6 ? kp_list[ph] : $urandom_range(0, 15));
         idle_on = (ph != 2);
         for (int k = 0; k < 26; k += n) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 70) : $urandom_range(1, 8);
            queue_set(n);
         end
         // One store-overflow set in phases 1 and 5.
         if (ph == 1 || ph == 5) queue_set(CAP + 3);
         drain();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
